@@ hdl/conv3_pkg.sv @@
// Package for the 3x3 ARGB convolution filter: sizes, field widths,
// register indexes and the sequencer state type. No dependencies.
`default_nettype none

package conv3_pkg;

    // Line store and frame limits
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int OROW_W     = $clog2(MAX_HEIGHT);
    localparam int IROW_W     = $clog2(MAX_HEIGHT + 1);

    // Register and field widths
    localparam int SIZE_W  = 11;
    localparam int KROW_W  = 24;
    localparam int DIV_W   = 8;
    localparam int CFG_W   = 24;
    localparam int IDX_W   = 3;
    localparam int PIX_W   = 32;
    localparam int PROD_W  = 17;
    localparam int SUM_W   = 20;
    localparam int REM_W   = 19;
    localparam int DSH_W   = 15;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_KTOP    = 3'd0;
    localparam logic [IDX_W-1:0] REG_KMID    = 3'd1;
    localparam logic [IDX_W-1:0] REG_KBOT    = 3'd2;
    localparam logic [IDX_W-1:0] REG_DIVISOR = 3'd3;
    localparam logic [IDX_W-1:0] REG_WIDTH   = 3'd4;
    localparam logic [IDX_W-1:0] REG_HEIGHT  = 3'd5;

    // Item kinds on tuser
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RMW,
        ST_MUL,
        ST_SUM,
        ST_PREP,
        ST_DIV,
        ST_OUT
    } seq_state_t;

endpackage

`default_nettype wire

@@ hdl/argb_conv3x3_filter.sv @@
// 3x3 convolution filter on an ARGB pixel stream, top level.
// Depends on conv3_pkg for sizes, register indexes and the state type.
`default_nettype none

// Takes 32-bit ARGB pixels in raster order on s_axis and returns each pixel
// filtered by a signed 3x3 kernel on m_axis, one line plus one pixel behind
// the input; flush items (tuser = 1) drain the last line of a frame, and tlast
// marks the last pixel. Items are processed one at a time: an item that
// yields a result passes through write back, multiply, sum, prepare, 8 divide
// steps and load into the result register, and the next item is taken once
// the load is done; the bit-serial restoring divide runs on the four
// channels in parallel. The load waits while the previous result is not yet
// taken. An item without a result passes through write back only, and an
// idle flush is taken without leaving the idle state. The next item is
// taken while a result still waits in the output register.
module argb_conv3x3_filter
    import conv3_pkg::*;
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire  [PIX_W-1:0]   s_axis_tdata,   // pixel_in [31:0]
    input  wire                s_axis_tuser,   // opcode [0]
    output logic               m_axis_tvalid,
    input  wire                m_axis_tready,
    output logic [PIX_W-1:0]   m_axis_tdata,   // pixel_out [31:0]
    output logic               m_axis_tlast,
    input  wire                cfg_write,
    input  wire  [IDX_W-1:0]   cfg_index,
    input  wire  [CFG_W-1:0]   cfg_data
);

    // Configuration registers
    logic [KROW_W-1:0] krow_reg [3];
    logic [DIV_W-1:0]  divisor_reg;
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;

    // Sequencer and counters
    seq_state_t        state_reg, state_next;
    logic [COL_W-1:0]  in_col_reg;
    logic [IROW_W-1:0] in_row_reg;
    logic [COL_W-1:0]  out_col_reg;
    logic [OROW_W-1:0] out_row_reg;

    // Line stores: mid line and top line
    logic [PIX_W-1:0]  mid_mem [MAX_WIDTH];
    logic [PIX_W-1:0]  top_mem [MAX_WIDTH];
    logic [PIX_W-1:0]  mid_q_reg;
    logic [PIX_W-1:0]  top_q_reg;

    // Item in flight
    logic [PIX_W-1:0]  pix_reg;
    logic [COL_W-1:0]  addr_reg;
    logic [PIX_W-1:0]  win_reg [9];
    logic              skip_t_reg, skip_b_reg, skip_l_reg, skip_r_reg;
    logic              fend_reg;

    // Arithmetic
    logic signed [PROD_W-1:0] prod_reg [4][9];
    logic signed [SUM_W-1:0]  sum_reg [4];
    logic [REM_W-1:0]  rem_reg [4];
    logic [7:0]        quo_reg [4];
    logic [3:0]        neg_reg, sat_reg;
    logic [DSH_W-1:0]  dsh_reg;
    logic [2:0]        step_reg;

    // Output register
    logic              ovalid_reg;
    logic [PIX_W-1:0]  odata_reg;
    logic              olast_reg;

    // Clamped sizes and derived values
    logic [SIZE_W-1:0] w_eff, h_eff;
    logic [DIV_W-1:0]  div_eff;
    logic [COL_W-1:0]  addr_sel;
    logic              accept, idle_flush, emit, in_wrap, out_wrap, last_out;
    logic              out_free;

    always_comb
    begin
        if (width_reg == '0)
            w_eff = SIZE_W'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            w_eff = SIZE_W'(MAX_WIDTH);
        else
            w_eff = width_reg;
        if (height_reg == '0)
            h_eff = SIZE_W'(1);
        else if (32'(height_reg) > MAX_HEIGHT)
            h_eff = SIZE_W'(MAX_HEIGHT);
        else
            h_eff = height_reg;
        div_eff = (divisor_reg == '0) ? DIV_W'(1) : divisor_reg;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign idle_flush    = (s_axis_tuser == OP_FLUSH) && (in_row_reg == '0)
                           && (in_col_reg == '0);
    assign addr_sel      = ({1'b0, in_col_reg} < w_eff) ? in_col_reg
                           : COL_W'(w_eff - SIZE_W'(1));
    assign emit          = (in_row_reg >= IROW_W'(2))
                           || ((in_row_reg == IROW_W'(1)) && (in_col_reg != '0));
    assign in_wrap       = ({1'b0, in_col_reg} + SIZE_W'(1)) >= w_eff;
    assign out_wrap      = ({1'b0, out_col_reg} + SIZE_W'(1)) >= w_eff;
    assign last_out      = out_wrap && (({1'b0, out_row_reg} + SIZE_W'(1)) >= h_eff);
    assign out_free      = !ovalid_reg || m_axis_tready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept && !idle_flush) state_next = ST_RMW;
            ST_RMW:  state_next = emit ? ST_MUL : ST_IDLE;
            ST_MUL:  state_next = ST_SUM;
            ST_SUM:  state_next = ST_PREP;
            ST_PREP: state_next = ST_DIV;
            ST_DIV:  if (step_reg == 3'd7) state_next = ST_OUT;
            ST_OUT:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            krow_reg[0] <= 24'h010101;
            krow_reg[1] <= 24'h010101;
            krow_reg[2] <= 24'h010101;
            divisor_reg <= 8'd9;
            width_reg   <= 11'd640;
            height_reg  <= 11'd480;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_KTOP:    krow_reg[0] <= cfg_data;
                REG_KMID:    krow_reg[1] <= cfg_data;
                REG_KBOT:    krow_reg[2] <= cfg_data;
                REG_DIVISOR: divisor_reg <= cfg_data[DIV_W-1:0];
                REG_WIDTH:   width_reg   <= cfg_data[SIZE_W-1:0];
                REG_HEIGHT:  height_reg  <= cfg_data[SIZE_W-1:0];
                default:     ;
            endcase
        end
    end

    // Read both line stores on accept, write back in the following cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mid_q_reg <= mid_mem[addr_sel];
            top_q_reg <= top_mem[addr_sel];
        end
        if (state_reg == ST_RMW)
        begin
            mid_mem[addr_reg] <= pix_reg;
            top_mem[addr_reg] <= mid_q_reg;
        end
    end

    // Latch item, shift window, capture edge masks
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_reg  <= ((s_axis_tuser == OP_PIXEL) && ({1'b0, in_row_reg} < 12'(h_eff)))
                        ? s_axis_tdata : '0;
            addr_reg <= addr_sel;
        end
        if (state_reg == ST_RMW)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r*3]   <= win_reg[r*3+1];
                win_reg[r*3+1] <= win_reg[r*3+2];
            end
            win_reg[2] <= top_q_reg;
            win_reg[5] <= mid_q_reg;
            win_reg[8] <= pix_reg;
            skip_t_reg <= (out_row_reg == '0);
            skip_b_reg <= ({1'b0, out_row_reg} + SIZE_W'(1)) >= h_eff;
            skip_l_reg <= (out_col_reg == '0);
            skip_r_reg <= out_wrap;
            fend_reg   <= last_out;
        end
    end

    // Advance position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else if (state_reg == ST_RMW)
        begin
            if (emit && last_out)
            begin
                in_col_reg  <= '0;
                in_row_reg  <= '0;
                out_col_reg <= '0;
                out_row_reg <= '0;
            end
            else
            begin
                if (in_wrap)
                begin
                    in_col_reg <= '0;
                    in_row_reg <= in_row_reg + IROW_W'(1);
                end
                else
                    in_col_reg <= in_col_reg + COL_W'(1);
                if (emit)
                begin
                    if (out_wrap)
                    begin
                        out_col_reg <= '0;
                        out_row_reg <= out_row_reg + OROW_W'(1);
                    end
                    else
                        out_col_reg <= out_col_reg + COL_W'(1);
                end
            end
        end
    end

    // Multiply each tap by its coefficient, masked at the image edges
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MUL)
        begin
            for (int ch = 0; ch < 4; ch++)
            begin
                for (int k = 0; k < 9; k++)
                begin
                    if ((k < 3 && skip_t_reg) || (k >= 6 && skip_b_reg)
                        || ((k % 3) == 0 && skip_l_reg) || ((k % 3) == 2 && skip_r_reg))
                        prod_reg[ch][k] <= '0;
                    else
                        prod_reg[ch][k] <= PROD_W'($signed({1'b0, win_reg[k][8*ch +: 8]})
                                           * $signed(krow_reg[k/3][8*(k%3) +: 8]));
                end
            end
        end
    end

    // Sum taps, then divide bit-serially; negative sums clamp to zero, large ones to 255
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SUM)
        begin
            for (int ch = 0; ch < 4; ch++)
            begin
                sum_reg[ch] <= SUM_W'(prod_reg[ch][0]) + SUM_W'(prod_reg[ch][1])
                             + SUM_W'(prod_reg[ch][2]) + SUM_W'(prod_reg[ch][3])
                             + SUM_W'(prod_reg[ch][4]) + SUM_W'(prod_reg[ch][5])
                             + SUM_W'(prod_reg[ch][6]) + SUM_W'(prod_reg[ch][7])
                             + SUM_W'(prod_reg[ch][8]);
            end
        end
        if (state_reg == ST_PREP)
        begin
            for (int ch = 0; ch < 4; ch++)
            begin
                neg_reg[ch] <= sum_reg[ch][SUM_W-1];
                rem_reg[ch] <= sum_reg[ch][REM_W-1:0];
                sat_reg[ch] <= sum_reg[ch][REM_W-1:0] >= {3'b0, div_eff, 8'b0};
                quo_reg[ch] <= '0;
            end
            dsh_reg <= {div_eff, 7'b0};
        end
        if (state_reg == ST_DIV)
        begin
            for (int ch = 0; ch < 4; ch++)
            begin
                if (rem_reg[ch] >= {4'b0, dsh_reg})
                begin
                    rem_reg[ch] <= rem_reg[ch] - {4'b0, dsh_reg};
                    quo_reg[ch] <= {quo_reg[ch][6:0], 1'b1};
                end
                else
                    quo_reg[ch] <= {quo_reg[ch][6:0], 1'b0};
            end
            dsh_reg <= dsh_reg >> 1;
        end
    end

    // Count divide steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= '0;
        else if (state_reg == ST_DIV)
            step_reg <= step_reg + 3'd1;
        else
            step_reg <= '0;
    end

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (state_reg == ST_OUT && out_free)
            ovalid_reg <= 1'b1;
        else if (m_axis_tready)
            ovalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT && out_free)
        begin
            for (int ch = 0; ch < 4; ch++)
                odata_reg[8*ch +: 8] <= neg_reg[ch] ? 8'd0
                                        : (sat_reg[ch] ? 8'd255 : quo_reg[ch]);
            olast_reg <= fend_reg;
        end
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;
    assign m_axis_tlast  = olast_reg;

    // Write back always follows a line store read
    a_rmw_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RMW |-> $past(state_reg) == ST_IDLE && $past(accept))
        else $error("write back without a preceding read");

    // A new result only comes from the load state
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg) == ST_OUT)
        else $error("result appeared outside the load state");

    // Divide runs exactly eight steps
    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_OUT && $past(state_reg) == ST_DIV |-> $past(step_reg) == 3'd7)
        else $error("divide left early");

endmodule

`default_nettype wire
